FILE: rtl/core/ctcg_pkg.sv
`default_nettype none
package ctcg_pkg;

	localparam int SCORE_W     = 16;
	localparam int SUM_W       = 26;
	localparam int CLASS_W     = 13;
	localparam int CLASS_CFG_W = 14;
	localparam int STEP_CFG_W  = 11;
	localparam int CFG_W       = 14;

	localparam logic [CLASS_CFG_W-1:0] CLASS_COUNT_RST = CLASS_CFG_W'(8192);
	localparam logic [STEP_CFG_W-1:0]  STEP_COUNT_RST  = STEP_CFG_W'(1024);

	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [0:0] {
		REG_CLASS_COUNT = 1'b0,
		REG_STEP_COUNT  = 1'b1
	} cfg_reg_t;

	// one finished time step, handed from the front to the back
	typedef struct packed {
		logic                      emit;
		logic                      seq_end;
		logic [CLASS_W-1:0]        label;
		logic signed [SCORE_W-1:0] score;
	} step_event_t;

endpackage
`default_nettype wire

FILE: rtl/core/ctcg_front.sv
`default_nettype none
module ctcg_front #(
	parameter int MAX_CLASSES = 8192,
	parameter int MAX_STEPS   = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ctcg_pkg::CLASS_CFG_W-1:0]    class_count,
	input  wire logic [ctcg_pkg::STEP_CFG_W-1:0]     step_count,
	input  wire logic                                score_valid,
	input  wire logic signed [ctcg_pkg::SCORE_W-1:0] score,
	output logic                                     score_stall,
	output logic                                     ev_push,
	output ctcg_pkg::step_event_t                    ev,
	input  wire logic                                ev_full
);
	import ctcg_pkg::*;

	localparam int CCW = $clog2(MAX_CLASSES);
	localparam int ECW = $clog2(MAX_CLASSES + 1);
	localparam int SCW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int ESW = $clog2(MAX_STEPS + 1) + 1;

	logic signed [SCORE_W-1:0] best_score_q;
	logic [CCW-1:0]            best_idx_q;
	logic [CCW-1:0]            class_cnt_q;
	logic [SCW-1:0]            step_cnt_q;
	logic [CCW-1:0]            prev_q;
	logic                      prev_valid_q;

	logic [ECW-1:0]            eff_cls;
	logic [ESW-1:0]            eff_steps;
	logic                      accept;
	logic                      better;
	logic signed [SCORE_W-1:0] cur_score;
	logic [CCW-1:0]            cur_idx;
	logic                      step_end;
	logic                      seq_end;
	logic                      blank;
	logic [31:0]               idx_wide;

	always_comb begin
		if (class_count < CLASS_CFG_W'(2))
			eff_cls = ECW'(2);
		else if (32'(class_count) > 32'(MAX_CLASSES))
			eff_cls = ECW'(MAX_CLASSES);
		else
			eff_cls = ECW'(class_count);

		if (step_count == '0)
			eff_steps = ESW'(1);
		else if (32'(step_count) > 32'(MAX_STEPS))
			eff_steps = ESW'(MAX_STEPS);
		else
			eff_steps = ESW'(step_count);
	end

	assign score_stall = ev_full;
	assign accept      = score_valid && !ev_full;

	// strictly greater: the first maximum keeps the win
	assign better    = score > best_score_q;
	assign cur_score = better ? score : best_score_q;
	assign cur_idx   = better ? class_cnt_q : best_idx_q;

	assign step_end = !((ECW'(class_cnt_q) + ECW'(1)) < eff_cls);
	assign seq_end  = step_end && !((ESW'(step_cnt_q) + ESW'(1)) < eff_steps);
	assign blank    = ECW'(cur_idx) == (eff_cls - ECW'(1));
	assign idx_wide = 32'(cur_idx);

	assign ev_push     = accept && step_end;
	assign ev.emit     = !blank && !(prev_valid_q && (cur_idx == prev_q));
	assign ev.seq_end  = seq_end;
	assign ev.label    = idx_wide[CLASS_W-1:0];
	assign ev.score    = cur_score;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= SCORE_MIN;
			best_idx_q   <= '0;
			class_cnt_q  <= '0;
			step_cnt_q   <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
		end else if (accept) begin
			if (step_end) begin
				best_score_q <= SCORE_MIN;
				best_idx_q   <= '0;
				class_cnt_q  <= '0;
				if (seq_end) begin
					step_cnt_q   <= '0;
					prev_q       <= '0;
					prev_valid_q <= 1'b0;
				end else begin
					step_cnt_q   <= step_cnt_q + SCW'(1);
					prev_q       <= cur_idx;
					prev_valid_q <= 1'b1;
				end
			end else begin
				best_score_q <= cur_score;
				best_idx_q   <= cur_idx;
				class_cnt_q  <= class_cnt_q + CCW'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ctcg_fifo.sv
`default_nettype none
module ctcg_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ctcg_pkg::step_event_t push_ev,
	output logic                       full,
	input  wire logic                  pop,
	output ctcg_pkg::step_event_t      pop_ev,
	output logic                       nonempty
);
	import ctcg_pkg::*;

	step_event_t mem_q [2];
	logic [1:0]  count_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic        do_push;
	logic        do_pop;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_ev   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ctcg_back.sv
`default_nettype none
module ctcg_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ctcg_pkg::step_event_t             ev,
	input  wire logic                              ev_nonempty,
	output logic                                   ev_pop,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic                                   kind,
	output logic [ctcg_pkg::CLASS_W-1:0]           class_index,
	output logic signed [ctcg_pkg::SUM_W-1:0]      seq_total,
	output logic                                   last
);
	import ctcg_pkg::*;

	logic                    result_valid_q;
	logic                    kind_q;
	logic [CLASS_W-1:0]      class_index_q;
	logic signed [SUM_W-1:0] seq_total_q;
	logic                    last_q;
	logic signed [SUM_W-1:0] running_sum_q;
	logic                    sum_pend_q;

	logic                    can_load;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_sat;

	assign can_load = !result_valid_q || !result_stall;
	assign ev_pop   = ev_nonempty && can_load && !sum_pend_q;

	always_comb begin
		sum_wide = {running_sum_q[SUM_W-1], running_sum_q}
			+ {{(SUM_W + 1 - SCORE_W){ev.score[SCORE_W-1]}}, ev.score};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			sum_sat = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			kind_q         <= 1'b0;
			class_index_q  <= '0;
			seq_total_q    <= '0;
			last_q         <= 1'b0;
			running_sum_q  <= '0;
			sum_pend_q     <= 1'b0;
		end else if (can_load) begin
			// drop the taken word unless a new one loads below
			result_valid_q <= 1'b0;
			if (sum_pend_q) begin
				result_valid_q <= 1'b1;
				kind_q         <= 1'b1;
				class_index_q  <= '0;
				seq_total_q    <= running_sum_q;
				last_q         <= 1'b1;
				running_sum_q  <= '0;
				sum_pend_q     <= 1'b0;
			end else if (ev_pop) begin
				if (ev.emit) begin
					result_valid_q <= 1'b1;
					kind_q         <= 1'b0;
					class_index_q  <= ev.label;
					seq_total_q    <= '0;
					last_q         <= 1'b0;
					running_sum_q  <= sum_sat;
					sum_pend_q     <= ev.seq_end;
				end else if (ev.seq_end) begin
					result_valid_q <= 1'b1;
					kind_q         <= 1'b1;
					class_index_q  <= '0;
					seq_total_q    <= sum_sat;
					last_q         <= 1'b1;
					running_sum_q  <= '0;
				end else begin
					running_sum_q  <= sum_sat;
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = kind_q;
	assign class_index  = class_index_q;
	assign seq_total    = seq_total_q;
	assign last         = last_q;

endmodule
`default_nettype wire

FILE: rtl/core/ctc_greedy_decoder.sv
// A label word passes the step queue and the back end's output register once the
// last score of its step is accepted; the sequence sum word follows it via the
// pending-sum flag (or comes alone). One score per cycle while score_stall is low;
// the back end issues one word per cycle unless stalled, so a two-entry step queue
// covers a label plus sum at the end of a sequence. Reset: config returns to 8192
// classes and 1024 steps, all decode state clears, and no word is presented.
`default_nettype none
module ctc_greedy_decoder #(
	parameter int MAX_CLASSES = 8192,
	parameter int MAX_STEPS   = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [ctcg_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                score_valid,
	output logic                                     score_stall,
	input  wire logic signed [ctcg_pkg::SCORE_W-1:0] score,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic                                     kind,
	output logic [ctcg_pkg::CLASS_W-1:0]             class_index,
	output logic signed [ctcg_pkg::SUM_W-1:0]        seq_total,
	output logic                                     last
);
	import ctcg_pkg::*;

	logic [CLASS_CFG_W-1:0] class_count_q;
	logic [STEP_CFG_W-1:0]  step_count_q;

	logic        push;
	step_event_t push_ev;
	logic        full;
	logic        pop;
	step_event_t pop_ev;
	logic        nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RST;
			step_count_q  <= STEP_COUNT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLASS_COUNT: class_count_q <= cfg_data[CLASS_CFG_W-1:0];
				REG_STEP_COUNT:  step_count_q  <= cfg_data[STEP_CFG_W-1:0];
				default:         class_count_q <= class_count_q;
			endcase
		end
	end

	ctcg_front #(
		.MAX_CLASSES(MAX_CLASSES),
		.MAX_STEPS  (MAX_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.class_count(class_count_q),
		.step_count (step_count_q),
		.score_valid(score_valid),
		.score      (score),
		.score_stall(score_stall),
		.ev_push    (push),
		.ev         (push_ev),
		.ev_full    (full)
	);

	ctcg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.full    (full),
		.pop     (pop),
		.pop_ev  (pop_ev),
		.nonempty(nonempty)
	);

	ctcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev          (pop_ev),
		.ev_nonempty (nonempty),
		.ev_pop      (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.class_index (class_index),
		.seq_total   (seq_total),
		.last        (last)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb_ctc_greedy_decoder.sv
`default_nettype none
module tb_ctc_greedy_decoder;
	import ctcg_pkg::*;

	localparam int N_CLASS_MAX = 8192;
	localparam int N_STEP_MAX  = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 4;
	localparam int HOLD_CYCLES = 300;

	localparam logic KIND_LABEL = 1'b0;
	localparam logic KIND_SUM   = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic [CLASS_W-1:0]      idx;
		logic signed [SUM_W-1:0] sum;
		logic                    last;
	} word_t;

	typedef enum int {ROW_SCORE, ROW_CLASSES, ROW_STEPS} row_op_e;

	typedef struct {
		row_op_e op;
		int      value;
		int      reps;
		bit      typed;
		int      n_exp;
		word_t   e0;
		word_t   e1;
	} row_t;

	typedef struct {
		int classes;
		int steps;
		int items;
	} phase_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write_en = 1'b0;
	cfg_reg_t                  cfg_index = REG_CLASS_COUNT;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      score_valid = 1'b0;
	logic                      score_stall;
	logic signed [SCORE_W-1:0] score = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic                      kind;
	logic [CLASS_W-1:0]        class_index;
	logic signed [SUM_W-1:0]   seq_total;
	logic                      last;

	ctc_greedy_decoder #(
		.MAX_CLASSES(N_CLASS_MAX),
		.MAX_STEPS  (N_STEP_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.score_valid (score_valid),
		.score_stall (score_stall),
		.score       (score),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.class_index (class_index),
		.seq_total   (seq_total),
		.last        (last)
	);

	word_t expected_words[$];
	row_t  rows[$];
	int    mismatch_count = 0;
	int    cycle_count = 0;
	int    snd_pct = 0;
	int    rcv_pct = 0;
	logic  hold_req = 1'b0;
	logic  hold_on = 1'b0;
	bit    hand_typed = 1'b0;

	// decoder state as the block should hold it
	int cfg_classes = int'(CLASS_COUNT_RST);
	int cfg_steps   = int'(STEP_COUNT_RST);
	int best_score  = int'(SCORE_MIN);
	int best_idx    = 0;
	int cls_cnt     = 0;
	int step_cnt    = 0;
	int prev_win    = 0;
	bit prev_ok     = 1'b0;
	int run_sum     = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("** ctc_greedy_decoder: FAILED **");
		$finish;
	end

	// long receiver hold-off so the step queue fills and the input stalls
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	function automatic word_t lbl(input int idx);
		word_t w;
		w = '0;
		w.kind = KIND_LABEL;
		w.idx = idx[CLASS_W-1:0];
		return w;
	endfunction

	function automatic word_t tot(input int sum);
		word_t w;
		w = '0;
		w.kind = KIND_SUM;
		w.sum = sum[SUM_W-1:0];
		w.last = 1'b1;
		return w;
	endfunction

	function automatic void add_row(input row_op_e op, input int value, input int reps,
			input bit typed, input int n_exp, input word_t e0, input word_t e1);
		row_t r;
		r.op = op;
		r.value = value;
		r.reps = reps;
		r.typed = typed;
		r.n_exp = n_exp;
		r.e0 = e0;
		r.e1 = e1;
		rows.insert(rows.size(), r);
	endfunction

	function automatic logic signed [SCORE_W-1:0] pick_score();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = int'($urandom);
			4, 5, 6:    v = int'($urandom_range(0, 6)) - 3;
			7:          v = int'(SCORE_MIN);
			8:          v = 32767;
			default:    v = int'($urandom_range(0, 2)) - 1;
		endcase
		return v[SCORE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// advance the argmax by one score and queue the words it finishes, unless typed by hand
	task automatic decode_score(input logic signed [SCORE_W-1:0] s);
		int ncls;
		int nst;
		int sc;
		ncls = cfg_classes < 2 ? 2 : (cfg_classes > N_CLASS_MAX ? N_CLASS_MAX : cfg_classes);
		nst = cfg_steps < 1 ? 1 : (cfg_steps > N_STEP_MAX ? N_STEP_MAX : cfg_steps);
		sc = int'(s);
		if (sc > best_score) begin
			best_score = sc;
			best_idx = cls_cnt;
		end
		if (cls_cnt + 1 < ncls) begin
			cls_cnt++;
			return;
		end
		if (best_idx != ncls - 1 && !(prev_ok && best_idx == prev_win) && !hand_typed)
			expected_words.insert(expected_words.size(), lbl(best_idx));
		prev_win = best_idx;
		prev_ok = 1'b1;
		run_sum = run_sum + best_score;
		if (run_sum > int'(SUM_MAX)) run_sum = int'(SUM_MAX);
		if (run_sum < int'(SUM_MIN)) run_sum = int'(SUM_MIN);
		best_score = int'(SCORE_MIN);
		best_idx = 0;
		cls_cnt = 0;
		if (step_cnt + 1 < nst) begin
			step_cnt++;
			return;
		end
		if (!hand_typed)
			expected_words.insert(expected_words.size(), tot(run_sum));
		step_cnt = 0;
		prev_win = 0;
		prev_ok = 1'b0;
		run_sum = 0;
	endtask

	task automatic send_score(input logic signed [SCORE_W-1:0] v);
		while ($urandom_range(0, 99) < snd_pct) begin
			score_valid <= 1'b0;
			@(posedge clk);
		end
		score_valid <= 1'b1;
		score <= v;
		@(posedge clk);
		while (score_stall) @(posedge clk);
		decode_score(v);
	endtask

	task automatic write_reg(input cfg_reg_t r, input int v);
		score_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[CFG_W-1:0];
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (r == REG_CLASS_COUNT)
			cfg_classes = v & 'h3FFF;
		else
			cfg_steps = v & 'h7FF;
	endtask

	always @(posedge clk) begin : watch_results
		word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing pending, kind", kind, 0);
			end else begin
				want = expected_words[0];
				expected_words.delete(0);
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (class_index !== want.idx)
					report_mismatch("class_index", class_index, want.idx);
				if (seq_total !== want.sum)
					report_mismatch("seq_total", seq_total, want.sum);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
		result_stall <= hold_on || ($urandom_range(0, 99) < rcv_pct);
	end

	initial begin
		phase_t plan[9];
		row_t r;
		plan = '{'{4, 3, 300}, '{1, 5, 150}, '{7, 2047, 200},
			'{16383, 1, 150}, '{0, 0, 100}, '{3, 2, 200},
			'{2, 1, 200}, '{6, 4, 250}, '{5, 7, 100}};

		// three classes under the reset step bound, peak just below the blank
		add_row(ROW_CLASSES, 3, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, -32768, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 32767, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 0, 1, 1, 1, lbl(1), '0);
		// shrink the step bound mid-sequence: the next step closes it
		add_row(ROW_STEPS, 1, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, 9, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 7, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 7, 1, 1, 2, lbl(0), tot(32776));
		// tie on first class, then a repeat, then a blank winner
		add_row(ROW_STEPS, 3, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, 100, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, -5, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 100, 1, 1, 1, lbl(0), '0);
		add_row(ROW_SCORE, 0, 3, 1, 0, '0, '0);
		add_row(ROW_SCORE, -1, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, -2, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, 300, 1, 1, 1, tot(400), '0);
		// all minimum scores: one label, then only repeats
		add_row(ROW_CLASSES, 2, 0, 0, 0, '0, '0);
		add_row(ROW_STEPS, 8, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, -32768, 16, 1, 2, lbl(0), tot(-262144));
		// zero registers clamp to two classes, one step
		add_row(ROW_CLASSES, 0, 0, 0, 0, '0, '0);
		add_row(ROW_STEPS, 0, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, 32767, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, -32768, 1, 1, 2, lbl(0), tot(32767));
		add_row(ROW_CLASSES, 1, 0, 0, 0, '0, '0);
		add_row(ROW_SCORE, -32768, 1, 0, 0, '0, '0);
		add_row(ROW_SCORE, -32767, 1, 1, 1, tot(-32767), '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_pct = 14;
		rcv_pct = 56;
		foreach (rows[i]) begin
			r = rows[i];
			case (r.op)
				ROW_CLASSES: write_reg(REG_CLASS_COUNT, r.value);
				ROW_STEPS:   write_reg(REG_STEP_COUNT, r.value);
				default: begin
					if (r.typed && r.n_exp > 0)
						expected_words.insert(expected_words.size(), r.e0);
					if (r.typed && r.n_exp > 1)
						expected_words.insert(expected_words.size(), r.e1);
					hand_typed = r.typed;
					repeat (r.reps) send_score(r.value[SCORE_W-1:0]);
					hand_typed = 1'b0;
				end
			endcase
		end

		foreach (plan[p]) begin
			case (p / 3)
				0: begin
					snd_pct = 14;
					rcv_pct = 56;
				end
				1: begin
					snd_pct = 56;
					rcv_pct = 14;
				end
				default: begin
					snd_pct = 0;
					rcv_pct = 0;
				end
			endcase
			write_reg(REG_CLASS_COUNT, plan[p].classes);
			write_reg(REG_STEP_COUNT, plan[p].steps);
			if (p == 6) hold_req = 1'b1;
			repeat (plan[p].items) send_score(pick_score());
		end

		score_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** ctc_greedy_decoder: PASSED **");
		else
			$display("** ctc_greedy_decoder: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
